[hw/rtl/rlqs_pkg.sv]
// shared types and constants of the link quality statistics block
package rlqs_pkg;

    localparam int CNT_W      = 16;
    localparam int SEQ_W      = 16;
    localparam int RSSI_W     = 8;
    localparam int TBYTES_W   = 8;
    localparam int TIME_W     = 16;
    localparam int QUAL_W     = 7;
    localparam int RATE_W     = 24;
    localparam int BYTES_W    = 32;
    localparam int OUT_CNT_W  = 16;
    localparam int SPAN_W     = TIME_W + 1;
    localparam int SCALE_W    = 10;
    localparam int DIV_W      = BYTES_W + SCALE_W;
    localparam int DVS_W      = (CNT_W > SPAN_W) ? CNT_W : SPAN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = SEQ_W + RSSI_W + TBYTES_W;
    localparam int OUT_DATA_W = 1 + QUAL_W + RSSI_W + 3 * OUT_CNT_W + RATE_W;

    localparam logic [TIME_W-1:0]    PERIOD_RESET = TIME_W'(1000);
    localparam logic [TIME_W-1:0]    WINDOW_RESET = TIME_W'(1000);
    localparam logic [TIME_W-1:0]    WIN_MAX      = TIME_W'(65534);
    localparam logic [TIME_W-1:0]    SINCE_MAX    = '1;
    localparam logic [DIV_W-1:0]     PCT_SCALE    = DIV_W'(100);
    localparam logic [DIV_W-1:0]     RATE_SCALE   = DIV_W'(1000);
    localparam logic [QUAL_W-1:0]    PCT_MAX      = QUAL_W'(100);
    localparam logic [RATE_W-1:0]    RATE_MAX     = '1;
    localparam logic [RSSI_W-1:0]    RSSI_NONE    = '1;

    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_PACKET   = 2'd1,
        OP_OVERFLOW = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUAL_START,
        ST_QUAL_WAIT,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic apply;
        logic q_start;
        logic q_zero;
        logic q_write;
        logic r_start;
        logic r_write;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic win_close;
        logic all_zero;
        logic div_done;
    } status_t;

endpackage

[hw/rtl/radio_link_quality_stats_top.sv]
// top level of the radio link quality statistics block
//
// channel   direction  transaction
// s_*       in         one event: tick, received packet or telemetry overflow
// m_*       out        one status record per event
// cfg_*     in         register write: failsafe period, statistics window
//
// an event is accepted, then its record is loaded into the output register once the output slot is free
// a window-closing tick first runs the bit-serial divider, once for quality and once for byte
// rate; the quality run is skipped and quality set to zero when the window saw no packets
// a result waiting on m_tready does not block acceptance of the next event
// reset clears all statistics; no memory sweep is needed
module radio_link_quality_stats_top
    import rlqs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sequence_id, link_rssi, telemetry_bytes
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // failsafe, link_quality, remote_rssi, packets_received, packets_missed,
    // overflow_count, telemetry_rate
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    rlqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rlqs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_user   (s_tuser),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

endmodule

[hw/rtl/rlqs_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module rlqs_div
    import rlqs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     rem_next;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DVS_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[hw/rtl/rlqs_dp.sv]
// datapath: counters, window marks, config registers, divider and result register
module rlqs_dp
    import rlqs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            in_user,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [TIME_W-1:0]     period_reg, period_next;
    logic [TIME_W-1:0]     window_reg, window_next;
    logic [SEQ_W-1:0]      last_seq_reg, last_seq_next;
    logic [CNT_W-1:0]      rcv_reg, rcv_next;
    logic [CNT_W-1:0]      miss_reg, miss_next;
    logic [CNT_W-1:0]      rcv_mark_reg, rcv_mark_next;
    logic [CNT_W-1:0]      miss_mark_reg, miss_mark_next;
    logic [CNT_W-1:0]      ovf_reg, ovf_next;
    logic [QUAL_W-1:0]     qual_reg, qual_next;
    logic [RSSI_W-1:0]     rssi_reg, rssi_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;
    logic [BYTES_W-1:0]    bytes_mark_reg, bytes_mark_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]     since_reg, since_next;
    logic [CNT_W-1:0]      ok_reg, ok_next;
    logic [CNT_W-1:0]      all_reg, all_next;
    logic [BYTES_W-1:0]    bdelta_reg, bdelta_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic [OUT_DATA_W-1:0] out_reg, out_next;

    opcode_t            op;
    logic [SEQ_W-1:0]   seq;
    logic [RSSI_W-1:0]  rssi;
    logic [TBYTES_W-1:0] tbytes;
    logic [TIME_W-1:0]  win;
    logic [TIME_W-1:0]  elapsed_inc;
    logic [SEQ_W-1:0]   gap;
    logic [CNT_W-1:0]   ok_delta;
    logic [CNT_W-1:0]   bad_delta;
    logic               fs;
    logic               div_start;
    logic [DIV_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
    logic [DIV_W-1:0]   quotient;
    logic               div_done;

    assign op          = opcode_t'(in_user);
    assign seq         = in_data[SEQ_W-1:0];
    assign rssi        = in_data[SEQ_W +: RSSI_W];
    assign tbytes      = in_data[SEQ_W + RSSI_W +: TBYTES_W];
    assign win         = (window_reg > WIN_MAX) ? WIN_MAX : window_reg;
    assign elapsed_inc = elapsed_reg + TIME_W'(1);
    assign gap         = seq - last_seq_reg;
    assign ok_delta    = rcv_reg - rcv_mark_reg;
    assign bad_delta   = miss_reg - miss_mark_reg;
    assign fs          = since_reg >= period_reg;

    assign status.win_close = (op == OP_TICK) && (elapsed_inc > win);
    assign status.all_zero  = all_reg == '0;
    assign status.div_done  = div_done;

    // shared divider: percentage first, then byte rate
    assign div_start = cmd.q_start | cmd.r_start;
    assign dividend  = cmd.q_start ? DIV_W'(ok_reg) * PCT_SCALE
                                   : DIV_W'(bdelta_reg) * RATE_SCALE;
    assign divisor   = cmd.q_start ? DVS_W'(all_reg) : DVS_W'(span_reg);

    rlqs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        period_next     = period_reg;
        window_next     = window_reg;
        last_seq_next   = last_seq_reg;
        rcv_next        = rcv_reg;
        miss_next       = miss_reg;
        rcv_mark_next   = rcv_mark_reg;
        miss_mark_next  = miss_mark_reg;
        ovf_next        = ovf_reg;
        qual_next       = qual_reg;
        rssi_next       = rssi_reg;
        bytes_next      = bytes_reg;
        bytes_mark_next = bytes_mark_reg;
        rate_next       = rate_reg;
        elapsed_next    = elapsed_reg;
        since_next      = since_reg;
        ok_next         = ok_reg;
        all_next        = all_reg;
        bdelta_next     = bdelta_reg;
        span_next       = span_reg;
        out_next        = out_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_FAILSAFE: period_next = TIME_W'(cfg_data);
                REG_WINDOW:   window_next = TIME_W'(cfg_data);
                default:      ;
            endcase
        end

        if (cmd.apply)
        begin
            case (op)
                OP_TICK:
                begin
                    if (since_reg != SINCE_MAX)
                        since_next = since_reg + TIME_W'(1);
                    if (status.win_close)
                    begin
                        elapsed_next    = '0;
                        ok_next         = ok_delta;
                        all_next        = ok_delta + bad_delta;
                        bdelta_next     = bytes_reg - bytes_mark_reg;
                        span_next       = SPAN_W'(win) + SPAN_W'(1);
                        rcv_mark_next   = rcv_reg;
                        miss_mark_next  = miss_reg;
                        bytes_mark_next = bytes_reg;
                    end
                    else
                        elapsed_next = elapsed_inc;
                end
                OP_PACKET:
                begin
                    rssi_next  = rssi;
                    bytes_next = bytes_reg + BYTES_W'(tbytes);
                    if (gap > SEQ_W'(1) && last_seq_reg != '0)
                        miss_next = miss_reg + CNT_W'(gap - SEQ_W'(1));
                    rcv_next      = rcv_reg + CNT_W'(1);
                    last_seq_next = seq;
                    since_next    = '0;
                end
                OP_OVERFLOW:
                    ovf_next = ovf_reg + CNT_W'(1);
                default: ;
            endcase
        end

        if (cmd.q_zero)
            qual_next = '0;
        if (cmd.q_write)
            qual_next = (quotient > DIV_W'(PCT_MAX)) ? PCT_MAX : quotient[QUAL_W-1:0];
        if (cmd.r_write)
            rate_next = (quotient > DIV_W'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];

        if (cmd.emit)
            out_next = {rate_reg,
                        OUT_CNT_W'(ovf_reg),
                        OUT_CNT_W'(miss_reg),
                        OUT_CNT_W'(rcv_reg),
                        fs ? RSSI_NONE : rssi_reg,
                        qual_reg,
                        fs};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            window_reg     <= WINDOW_RESET;
            last_seq_reg   <= '0;
            rcv_reg        <= '0;
            miss_reg       <= '0;
            rcv_mark_reg   <= '0;
            miss_mark_reg  <= '0;
            ovf_reg        <= '0;
            qual_reg       <= '0;
            rssi_reg       <= RSSI_NONE;
            bytes_reg      <= '0;
            bytes_mark_reg <= '0;
            rate_reg       <= '0;
            elapsed_reg    <= '0;
            since_reg      <= PERIOD_RESET;
        end
        else
        begin
            period_reg     <= period_next;
            window_reg     <= window_next;
            last_seq_reg   <= last_seq_next;
            rcv_reg        <= rcv_next;
            miss_reg       <= miss_next;
            rcv_mark_reg   <= rcv_mark_next;
            miss_mark_reg  <= miss_mark_next;
            ovf_reg        <= ovf_next;
            qual_reg       <= qual_next;
            rssi_reg       <= rssi_next;
            bytes_reg      <= bytes_next;
            bytes_mark_reg <= bytes_mark_next;
            rate_reg       <= rate_next;
            elapsed_reg    <= elapsed_next;
            since_reg      <= since_next;
        end
    end

    // window snapshot and result payload
    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        all_reg    <= all_next;
        bdelta_reg <= bdelta_next;
        span_reg   <= span_next;
        out_reg    <= out_next;
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/rlqs_ctrl.sv]
// controller: event acceptance, window close sequencing and result handshake
module rlqs_ctrl
    import rlqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = status.win_close ? ST_QUAL_START : ST_EMIT;
                end
            end
            ST_QUAL_START:
            begin
                if (status.all_zero)
                begin
                    cmd.q_zero = 1'b1;
                    state_next = ST_RATE_START;
                end
                else
                begin
                    cmd.q_start = 1'b1;
                    state_next  = ST_QUAL_WAIT;
                end
            end
            ST_QUAL_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.q_write = 1'b1;
                    state_next  = ST_RATE_START;
                end
            end
            ST_RATE_START:
            begin
                cmd.r_start = 1'b1;
                state_next  = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.r_write = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/rlqs_checker.sv]
// port-level checker for the link quality statistics block, bound to the top level
module rlqs_checker
    import rlqs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // one event at a time
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // failsafe forces the rssi field to minus one
    a_fs_rssi: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[15:8] == RSSI_NONE)
        else $error("rssi not cleared in failsafe");

    a_qual_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[QUAL_W:1] <= PCT_MAX)
        else $error("link quality above one hundred");

endmodule

bind radio_link_quality_stats_top rlqs_checker u_rlqs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/radio_link_quality_stats_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the radio link quality statistics block
module radio_link_quality_stats_top_tb;
    import rlqs_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         IDLE_PCT     = 11;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         CLOSE_CYCLES = 2 * (DIV_W + 2) + 8;
    localparam int         PHASE_ITEMS  = 350;
    localparam int         SILENCE_TICKS = 60;

    typedef struct {
        logic                 failsafe;
        logic [QUAL_W-1:0]    quality;
        logic [RSSI_W-1:0]    rssi;
        logic [OUT_CNT_W-1:0] received;
        logic [OUT_CNT_W-1:0] missed;
        logic [OUT_CNT_W-1:0] overflows;
        logic [RATE_W-1:0]    rate;
    } link_status_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted block state
    logic [TIME_W-1:0]  period_ms;
    logic [TIME_W-1:0]  window_len;
    logic [SEQ_W-1:0]   last_seq;
    logic [CNT_W-1:0]   rx_count;
    logic [CNT_W-1:0]   miss_count;
    logic [CNT_W-1:0]   rx_mark;
    logic [CNT_W-1:0]   miss_mark;
    logic [QUAL_W-1:0]  quality;
    logic [RSSI_W-1:0]  strength;
    logic [BYTES_W-1:0] bytes_total;
    logic [BYTES_W-1:0] bytes_mark;
    logic [RATE_W-1:0]  rate;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  since_pkt;
    logic [CNT_W-1:0]   overflow_events;

    link_status_t pending_status[$];
    link_status_t want_status;

    logic [SEQ_W-1:0] seq_cursor = '0;
    bit  quiet_mode     = 1'b0;
    int  mismatch_count = 0;
    int  events_sent    = 0;
    int  status_checked = 0;
    int  reg_writes     = 0;
    int  stall_cycles   = 0;

    radio_link_quality_stats_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic clear_link_state();
        period_ms       = PERIOD_RESET;
        window_len      = WINDOW_RESET;
        last_seq        = '0;
        rx_count        = '0;
        miss_count      = '0;
        rx_mark         = '0;
        miss_mark       = '0;
        quality         = '0;
        strength        = RSSI_NONE;
        bytes_total     = '0;
        bytes_mark      = '0;
        rate            = '0;
        elapsed         = '0;
        since_pkt       = PERIOD_RESET;
        overflow_events = '0;
    endtask

    task automatic close_stats_window(input logic [SPAN_W-1:0] span);
        logic [CNT_W-1:0]   ok;
        logic [CNT_W-1:0]   bad;
        logic [CNT_W-1:0]   total;
        logic [BYTES_W-1:0] byte_diff;
        longint unsigned    pct;
        longint unsigned    bps;
        ok    = rx_count - rx_mark;
        bad   = miss_count - miss_mark;
        total = ok + bad;
        if (total != '0)
        begin
            pct     = ok;
            pct     = pct * 100 / total;
            quality = (pct > 100) ? PCT_MAX : QUAL_W'(pct);
        end
        else
        begin
            quality = '0;
        end
        rx_mark   = rx_count;
        miss_mark = miss_count;
        byte_diff = bytes_total - bytes_mark;
        bps       = byte_diff;
        bps       = bps * 1000 / span;
        rate      = (bps > RATE_MAX) ? RATE_MAX : RATE_W'(bps);
        bytes_mark = bytes_total;
    endtask

    task automatic predict_link_status(input logic [1:0] op, input logic [SEQ_W-1:0] seq,
                                       input logic [RSSI_W-1:0] rssi,
                                       input logic [TBYTES_W-1:0] tbytes);
        logic [TIME_W-1:0] win;
        logic [SEQ_W-1:0]  gap;
        link_status_t      st;
        case (op)
            OP_TICK:
            begin
                win = (window_len > WIN_MAX) ? WIN_MAX : window_len;
                if (since_pkt < SINCE_MAX)
                    since_pkt = since_pkt + 1'b1;
                elapsed = elapsed + 1'b1;
                if (elapsed > win)
                begin
                    close_stats_window(SPAN_W'(win) + 1'b1);
                    elapsed = '0;
                end
            end
            OP_PACKET:
            begin
                gap         = seq - last_seq;
                strength    = rssi;
                bytes_total = bytes_total + tbytes;
                if (gap > 1 && last_seq != '0)
                    miss_count = miss_count + CNT_W'(gap - 1'b1);
                rx_count  = rx_count + 1'b1;
                last_seq  = seq;
                since_pkt = '0;
            end
            OP_OVERFLOW:
                overflow_events = overflow_events + 1'b1;
            default:
                ;
        endcase
        st.failsafe  = (since_pkt >= period_ms);
        st.quality   = quality;
        st.rssi      = st.failsafe ? RSSI_NONE : strength;
        st.received  = rx_count;
        st.missed    = miss_count;
        st.overflows = overflow_events;
        st.rate      = rate;
        pending_status.push_back(st);
    endtask

    task automatic send_event(input logic [1:0] op, input logic [SEQ_W-1:0] seq,
                              input logic [RSSI_W-1:0] rssi, input logic [TBYTES_W-1:0] tbytes);
        int gap_len;
        @(negedge clk);
        if (!quiet_mode && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            gap_len  = $urandom_range(6, 1);
            repeat (gap_len) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {tbytes, rssi, seq};
        s_tuser  = op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_link_status(op, seq, rssi, tbytes);
        events_sent++;
    endtask

    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TBYTES_W-1:0] tbytes);
        send_event(OP_PACKET, seq, RSSI_W'($urandom_range(255)), tbytes);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (CLOSE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_FAILSAFE)
            period_ms = val;
        else if (idx == REG_WINDOW)
            window_len = val;
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_event();
        int               pick;
        int               seq_pick;
        logic [SEQ_W-1:0] seq;
        pick = $urandom_range(99);
        seq  = SEQ_W'($urandom_range(65535));
        if (pick < 45)
            send_event(OP_TICK, seq, RSSI_W'($urandom_range(255)), TBYTES_W'($urandom_range(255)));
        else if (pick < 85)
        begin
            seq_pick = $urandom_range(99);
            if (seq_pick < 78)
                seq = seq_cursor + 1'b1;
            else if (seq_pick < 88)
                seq = seq_cursor + SEQ_W'($urandom_range(6, 2));
            else if (seq_pick < 97 && seq_pick >= 94)
                seq = seq_cursor;
            else if (seq_pick >= 97)
                seq = '0;
            seq_cursor = seq;
            send_packet(seq, TBYTES_W'($urandom_range(255)));
        end
        else if (pick < 95)
            send_event(OP_OVERFLOW, seq, RSSI_W'($urandom_range(255)),
                       TBYTES_W'($urandom_range(255)));
        else
            send_event(OP_UNUSED, seq, RSSI_W'($urandom_range(255)),
                       TBYTES_W'($urandom_range(255)));
    endtask

    task automatic test_directed_events();
        send_event(OP_UNUSED, 16'hFFFF, 8'h7F, 8'hFF);
        send_event(OP_TICK, '0, '0, '0);
        send_event(OP_PACKET, 16'd0, 8'h80, 8'hFF);
        send_event(OP_PACKET, 16'hFFFF, 8'h7F, 8'h00);
        // wrap past zero, then a repeat and a step backwards
        send_event(OP_PACKET, 16'd5, 8'hFF, 8'h01);
        send_event(OP_PACKET, 16'd5, 8'h00, 8'h80);
        send_event(OP_PACKET, 16'd4, 8'h01, 8'h7F);
        send_event(OP_OVERFLOW, '0, '0, '0);
        send_event(OP_OVERFLOW, 16'hFFFF, 8'hFF, 8'hFF);
        send_event(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF);
        send_event(OP_UNUSED, 16'h1234, 8'hA5, 8'h5A);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_FAILSAFE, '0);
        write_reg(REG_WINDOW, '0);
        send_event(OP_TICK, '0, '0, '0);
        send_event(OP_TICK, '0, '0, '0);
        send_packet(16'd200, 8'd10);
        send_event(OP_TICK, '0, '0, '0);
        // received and missed deltas summing to zero, then to one
        send_packet(16'd201, 8'd20);
        send_packet(16'd200, 8'd30);
        send_event(OP_TICK, '0, '0, '0);
        send_packet(16'd201, 8'd40);
        send_packet(16'd200, 8'd50);
        send_packet(16'd201, 8'd60);
        send_event(OP_TICK, '0, '0, '0);
        wait_idle();
        write_reg(REG_FAILSAFE, 16'hFFFF);
        write_reg(REG_WINDOW, 16'hFFFF);
        send_packet(16'd202, 8'd70);
        send_event(OP_TICK, '0, '0, '0);
        send_event(OP_TICK, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_rate_limits();
        write_reg(REG_FAILSAFE, 16'd5);
        write_reg(REG_WINDOW, '0);
        repeat (70)
        begin
            seq_cursor = seq_cursor + 1'b1;
            send_packet(seq_cursor, 8'hFF);
        end
        send_event(OP_TICK, '0, '0, '0);
        repeat (60)
        begin
            seq_cursor = seq_cursor + 1'b1;
            send_packet(seq_cursor, 8'hFF);
        end
        send_event(OP_TICK, '0, '0, '0);
        wait_idle();
        write_reg(REG_WINDOW, 16'd1);
        repeat (40)
        begin
            seq_cursor = seq_cursor + 1'b1;
            send_packet(seq_cursor, TBYTES_W'($urandom_range(255)));
        end
        repeat (3) send_event(OP_TICK, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_FAILSAFE, CFG_DATA_W'($urandom_range(40, 1)));
                    write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(20)));
                end
                1:
                begin
                    write_reg(REG_FAILSAFE, 16'd1);
                    write_reg(REG_WINDOW, 16'd1);
                end
                2:
                begin
                    write_reg(REG_FAILSAFE, CFG_DATA_W'($urandom_range(200)));
                    write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(100, 10)));
                end
                default:
                begin
                    write_reg(REG_FAILSAFE, 16'hFFFF);
                    write_reg(REG_WINDOW, WIN_MAX);
                end
            endcase
            // first phase runs with no idling on either side
            quiet_mode = (phase == 0);
            repeat (PHASE_ITEMS) random_event();
            wait_idle();
            quiet_mode = 1'b0;
        end
    endtask

    task automatic test_long_silence();
        write_reg(REG_FAILSAFE, 16'd50);
        write_reg(REG_WINDOW, 16'hFFFF);
        seq_cursor = seq_cursor + 1'b1;
        send_packet(seq_cursor, 8'd99);
        repeat (SILENCE_TICKS) send_event(OP_TICK, '0, '0, '0);
        seq_cursor = seq_cursor + 1'b1;
        send_packet(seq_cursor, 8'd1);
        send_event(OP_TICK, '0, '0, '0);
        wait_idle();
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(negedge clk)
        m_tready = quiet_mode || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_status.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: unexpected status transaction, expected none actual %0h",
                         $time, m_tdata);
            end
            else
            begin
                want_status = pending_status.pop_front();
                compare_field("failsafe", want_status.failsafe, m_tdata[0]);
                compare_field("link_quality", want_status.quality, m_tdata[7:1]);
                compare_field("remote_rssi", want_status.rssi, m_tdata[15:8]);
                compare_field("packets_received", want_status.received, m_tdata[31:16]);
                compare_field("packets_missed", want_status.missed, m_tdata[47:32]);
                compare_field("overflow_count", want_status.overflows, m_tdata[63:48]);
                compare_field("telemetry_rate", want_status.rate, m_tdata[87:64]);
            end
            status_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles, %0d status transactions pending",
                     $time, stall_cycles, pending_status.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clear_link_state();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_events();
        test_register_extremes();
        test_rate_limits();
        test_random_traffic();
        test_long_silence();

        $display("%0d events sent, %0d status transactions checked, %0d register writes",
                 events_sent, status_checked, reg_writes);
        $display("sequence gaps and wraps, window closes, quality and rate limits, long silence");
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
